/* rtl/core/text_terminal_print_engine_assert.svh */
// assertion macros for the checker of the print engine
`ifndef TEXT_TERMINAL_PRINT_ENGINE_ASSERT_SVH
`define TEXT_TERMINAL_PRINT_ENGINE_ASSERT_SVH

// implication checked at every clock edge outside reset
`define TTPE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttpe assertion failed");

// next-cycle implication checked outside reset
`define TTPE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttpe assertion failed");

// next-cycle implication that also holds across reset
`define TTPE_ASSERT_NXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ttpe assertion failed");

`endif

/* rtl/core/ttpe_pkg.sv */
package ttpe_pkg;

  localparam int COLS     = 80;
  localparam int MAX_ROWS = 128;
  localparam int DEPTH    = COLS * MAX_ROWS;
  localparam int AW       = $clog2(DEPTH);

  localparam logic [2:0] CMD_PRINT   = 3'd0;
  localparam logic [2:0] CMD_PUT     = 3'd1;
  localparam logic [2:0] CMD_GOTO    = 3'd2;
  localparam logic [2:0] CMD_SCROLL  = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_FF = 8'h0C;

  localparam logic [2:0] REG_AREA_LEFT   = 3'd0;
  localparam logic [2:0] REG_AREA_TOP    = 3'd1;
  localparam logic [2:0] REG_AREA_WIDTH  = 3'd2;
  localparam logic [2:0] REG_AREA_ROWS   = 3'd3;
  localparam logic [2:0] REG_SCREEN_ROWS = 3'd4;
  localparam logic [2:0] REG_COLOR_BACK  = 3'd5;
  localparam logic [2:0] REG_COLOR_FORE  = 3'd6;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         data_byte;
    logic [6:0]         pos_x;
    logic [6:0]         pos_y;
    logic signed [15:0] scroll_amount;
  } cmd_item_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [6:0] cursor_row;
    logic [7:0] cell_char;
    logic [5:0] cell_back;
    logic [5:0] cell_fore;
  } res_item_t;

  // row pass descriptor: copy rows, then clear rows
  typedef struct packed {
    logic       copy;
    logic       down;
    logic       lf;
    logic [7:0] row_i;
    logic [7:0] row_n;
    logic [7:0] clr_n;
    logic [7:0] bh;
    logic [8:0] clr_base;
  } job_t;

endpackage

/* rtl/core/text_terminal_print_engine.sv */
// text terminal print engine: one command item in, one result item out, one at a time
// an item passes the execute state (a read also a read-wait state) and the output
// state, which loads the result; row work: a row state per blanked cell, a row state
// and a copy-write state per copied cell; reset: synchronous; a clearing pass writes
// all 10240 cells, no item is taken meanwhile, configuration writes are taken as ever
module text_terminal_print_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ttpe_pkg::cmd_item_t cmd_item,
  output logic                res_valid,
  input  logic                res_ready,
  output ttpe_pkg::res_item_t res_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ttpe_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EXEC, S_ROW, S_CPWR, S_RDWAIT, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [6:0] area_left, area_top, area_width;
  logic [7:0] area_rows, screen_rows;
  logic [5:0] color_back, color_fore;

  // working registers
  cmd_item_t item;
  logic [6:0] cur_x, cur_y;
  job_t       job;
  logic [7:0] col;
  logic       src_ok, rd_ok;
  logic [7:0] cell_char;
  logic [5:0] cell_back, cell_fore;
  logic [AW-1:0] init_cnt;

  // cell store: char in [19:12], background [11:6], foreground [5:0]
  logic [19:0]   mem [DEPTH];
  logic [19:0]   rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [19:0]   mem_wdata;

  function automatic logic [AW-1:0] cell_addr(input logic [8:0] y, input logic [7:0] x);
    cell_addr = AW'(y[6:0]) * AW'(COLS) + AW'(x[6:0]);
  endfunction

  logic [8:0] rows_eff;
  function automatic logic on_screen(input logic [7:0] x, input logic [8:0] y,
                                     input logic [8:0] re);
    on_screen = (x < 8'(COLS)) && (y < re);
  endfunction

  // area geometry
  logic [7:0] col_end;
  logic [8:0] bot;
  assign col_end  = {1'b0, area_left} + {1'b0, area_width};
  assign bot      = {2'b0, area_top} + {1'b0, area_rows};
  assign rows_eff = (screen_rows > 8'(MAX_ROWS)) ? 9'(MAX_ROWS) : {1'b0, screen_rows};

  // scroll setup, shared by scroll command, line feed and print at area end
  logic               sc_sel, sc_neg, sc_full;
  logic signed [15:0] sc_d;
  logic [15:0]        sc_bh;
  logic [7:0]         sc_ph;
  logic [6:0]         sc_cur_y;
  job_t               sc_job, clr_job, lf_job, clr_phase_job;

  always_comb begin
    sc_sel  = (state == S_EXEC) && (item.cmd == CMD_SCROLL);
    sc_d    = sc_sel ? item.scroll_amount : 16'sd1;
    sc_neg  = sc_d[15];
    sc_bh   = sc_neg ? 16'(-sc_d) : 16'(sc_d);
    sc_full = sc_bh >= {8'b0, area_rows};
    sc_ph   = area_rows - sc_bh[7:0];
    sc_job.copy     = !sc_full;
    sc_job.down     = sc_neg;
    sc_job.lf       = 1'b0;
    sc_job.row_i    = 8'd0;
    sc_job.row_n    = sc_full ? area_rows : sc_ph;
    sc_job.clr_n    = sc_bh[7:0];
    sc_job.bh       = sc_bh[7:0];
    sc_job.clr_base = (sc_full || sc_neg) ? {2'b0, area_top}
                                          : {2'b0, area_top} + {1'b0, sc_ph};
    if (sc_neg) begin
      sc_cur_y = area_top;
    end else if (sc_full) begin
      sc_cur_y = 7'(bot - 9'd1);
    end else begin
      sc_cur_y = 7'(bot - {1'b0, sc_bh[7:0]});
    end
    clr_job          = '0;
    clr_job.row_n    = area_rows;
    clr_job.clr_base = {2'b0, area_top};
    // blank the rest of the cursor row
    lf_job          = '0;
    lf_job.lf       = 1'b1;
    lf_job.row_n    = 8'd1;
    lf_job.clr_base = {2'b0, cur_y};
    // copy phase done, go on with the blank rows
    clr_phase_job       = job;
    clr_phase_job.copy  = 1'b0;
    clr_phase_job.row_i = 8'd0;
    clr_phase_job.row_n = job.clr_n;
  end

  // row pass addressing
  logic [8:0] dst_y, src_y;
  always_comb begin
    if (job.copy) begin
      dst_y = job.down ? (bot - 9'd1 - {1'b0, job.row_i})
                       : ({2'b0, area_top} + {1'b0, job.row_i});
    end else begin
      dst_y = job.clr_base + {1'b0, job.row_i};
    end
    src_y = job.down ? (dst_y - {1'b0, job.bh}) : (dst_y + {1'b0, job.bh});
  end

  // command decode helpers
  logic       is_ctl, do_write, row_busy;
  logic [7:0] x1;
  logic [8:0] y1;
  assign is_ctl   = (item.data_byte == CH_CR) || (item.data_byte == CH_LF) ||
                    (item.data_byte == CH_FF);
  assign do_write = ((item.cmd == CMD_PRINT) && !is_ctl) || (item.cmd == CMD_PUT);
  assign x1       = {1'b0, cur_x} + 8'd1;
  assign y1       = {2'b0, cur_y} + 9'd1;
  assign row_busy = (job.row_i != job.row_n) && (col < col_end);

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(dst_y, col);
    mem_wdata = {8'd0, color_back, color_fore};
    mem_re    = 1'b0;
    mem_raddr = cell_addr(src_y, col);
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt;
        mem_wdata = '0;
      end
      S_EXEC: begin
        mem_we    = do_write && on_screen({1'b0, cur_x}, {2'b0, cur_y}, rows_eff);
        mem_waddr = cell_addr({2'b0, cur_y}, {1'b0, cur_x});
        mem_wdata = {item.data_byte, color_back, color_fore};
        mem_re    = (item.cmd == CMD_READ) &&
                    on_screen({1'b0, item.pos_x}, {2'b0, item.pos_y}, rows_eff);
        mem_raddr = cell_addr({2'b0, item.pos_y}, {1'b0, item.pos_x});
      end
      S_ROW: begin
        mem_we = row_busy && !job.copy && on_screen(col, dst_y, rows_eff);
        mem_re = row_busy && job.copy && on_screen(col, src_y, rows_eff);
      end
      S_CPWR: begin
        mem_we    = on_screen(col, dst_y, rows_eff);
        mem_wdata = src_ok ? rd_q : '0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_left   <= 7'd0;
      area_top    <= 7'd0;
      area_width  <= 7'd80;
      area_rows   <= 8'd30;
      screen_rows <= 8'd30;
      color_back  <= 6'd0;
      color_fore  <= 6'd63;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_AREA_LEFT:   area_left   <= pwdata[6:0];
        REG_AREA_TOP:    area_top    <= pwdata[6:0];
        REG_AREA_WIDTH:  area_width  <= pwdata[6:0];
        REG_AREA_ROWS:   area_rows   <= pwdata[7:0];
        REG_SCREEN_ROWS: screen_rows <= pwdata[7:0];
        REG_COLOR_BACK:  color_back  <= pwdata[5:0];
        REG_COLOR_FORE:  color_fore  <= pwdata[5:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_AREA_LEFT:   prdata = {25'd0, area_left};
      REG_AREA_TOP:    prdata = {25'd0, area_top};
      REG_AREA_WIDTH:  prdata = {25'd0, area_width};
      REG_AREA_ROWS:   prdata = {24'd0, area_rows};
      REG_SCREEN_ROWS: prdata = {24'd0, screen_rows};
      REG_COLOR_BACK:  prdata = {26'd0, color_back};
      REG_COLOR_FORE:  prdata = {26'd0, color_fore};
      default:         prdata = 32'd0;
    endcase
  end

  assign cmd_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_cnt  <= '0;
      cur_x     <= 7'd0;
      cur_y     <= 7'd0;
      res_valid <= 1'b0;
    end else begin
      // the output state reloads the result register itself
      if (res_valid && res_ready && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        // clearing pass over the whole store after reset
        S_INIT: begin
          init_cnt <= init_cnt + AW'(1);
          if (init_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            item  <= cmd_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          cell_char <= 8'd0;
          cell_back <= 6'd0;
          cell_fore <= 6'd0;
          state     <= S_OUT;
          unique case (item.cmd)
            CMD_PRINT, CMD_PUT: begin
              if ((item.cmd == CMD_PRINT) && (item.data_byte == CH_CR)) begin
                cur_x <= area_left;
              end else if ((item.cmd == CMD_PRINT) && (item.data_byte == CH_LF)) begin
                // blank the rest of the line, then move down
                job   <= lf_job;
                col   <= {1'b0, cur_x};
                state <= S_ROW;
              end else if ((item.cmd == CMD_PRINT) && (item.data_byte == CH_FF)) begin
                job   <= clr_job;
                col   <= {1'b0, area_left};
                cur_x <= area_left;
                cur_y <= 7'(bot - 9'd1);
                state <= S_ROW;
              end else if (x1 >= col_end) begin
                cur_x <= area_left;
                if (y1 >= bot) begin
                  if (item.cmd == CMD_PRINT) begin
                    // past the bottom: scroll up one line
                    job   <= sc_job;
                    col   <= {1'b0, area_left};
                    cur_y <= sc_cur_y;
                    state <= S_ROW;
                  end else begin
                    cur_y <= area_top;
                  end
                end else begin
                  cur_y <= y1[6:0];
                end
              end else begin
                cur_x <= x1[6:0];
              end
            end
            CMD_GOTO: begin
              if ((item.pos_x < area_width) && ({1'b0, item.pos_y} < area_rows)) begin
                cur_x <= area_left + item.pos_x;
                cur_y <= area_top + item.pos_y;
              end
            end
            CMD_SCROLL: begin
              if (item.scroll_amount != 16'sd0) begin
                job   <= sc_job;
                col   <= {1'b0, area_left};
                cur_x <= area_left;
                cur_y <= sc_cur_y;
                state <= S_ROW;
              end
            end
            CMD_CLEAR: begin
              job   <= clr_job;
              col   <= {1'b0, area_left};
              state <= S_ROW;
            end
            CMD_READ: begin
              rd_ok <= on_screen({1'b0, item.pos_x}, {2'b0, item.pos_y}, rows_eff);
              state <= S_RDWAIT;
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        // clears write a cell here, copies read here and write in the copy-write state
        S_ROW: begin
          if (job.row_i == job.row_n) begin
            if (job.copy) begin
              job <= clr_phase_job;
              col <= {1'b0, area_left};
            end else if (job.lf) begin
              cur_x <= area_left;
              if (y1 >= bot) begin
                job   <= sc_job;
                col   <= {1'b0, area_left};
                cur_y <= sc_cur_y;
              end else begin
                cur_y <= y1[6:0];
                state <= S_OUT;
              end
            end else begin
              state <= S_OUT;
            end
          end else if (col >= col_end) begin
            job.row_i <= job.row_i + 8'd1;
            col       <= {1'b0, area_left};
          end else if (job.copy) begin
            src_ok <= on_screen(col, src_y, rows_eff);
            state  <= S_CPWR;
          end else begin
            col <= col + 8'd1;
          end
        end
        S_CPWR: begin
          col   <= col + 8'd1;
          state <= S_ROW;
        end
        S_RDWAIT: begin
          cell_char <= rd_ok ? rd_q[19:12] : 8'd0;
          cell_back <= rd_ok ? rd_q[11:6] : 6'd0;
          cell_fore <= rd_ok ? rd_q[5:0] : 6'd0;
          state     <= S_OUT;
        end
        // output register frees the core once loaded
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            res_item  <= '{cursor_col: cur_x, cursor_row: cur_y, cell_char: cell_char,
                           cell_back: cell_back, cell_fore: cell_fore};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/ttpe_checker.sv */
module ttpe_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                res_valid,
  input logic                res_ready,
  input ttpe_pkg::res_item_t res_item,
  input logic                pready
);
  `include "text_terminal_print_engine_assert.svh"

  `TTPE_ASSERT_IMP(a_pready_high, 1'b1, pready)
  `TTPE_ASSERT_NXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)
  `TTPE_ASSERT_NXT_RST(a_quiet_after_reset, rst, !res_valid && !cmd_ready)
  `TTPE_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item))

endmodule

bind text_terminal_print_engine ttpe_checker u_ttpe_checker (.*);

/* verif/text_terminal_print_engine_test.sv */
`timescale 1ns / 100ps

module text_terminal_print_engine_test;
  import ttpe_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  cmd_item_t   cmd_item = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_item_t   res_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_terminal_print_engine uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_item(cmd_item),
    .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the screen: character and colour stores plus cursor
  byte unsigned char_mem [DEPTH];
  bit [11:0]    color_mem [DEPTH];
  logic [6:0]   cur_x = 7'd0, cur_y = 7'd0;

  // mirror of the registers
  int a_left = 0, a_top = 0, a_width = 80, a_height = 30;
  int scr_rows = 30, col_back = 0, col_fore = 63;

  cmd_item_t queued_cmds[$];
  res_item_t pending_results[$];
  int        mismatches = 0;
  bit        quiet = 1'b0;   // no idling in the final stretch
  int        snd_gap = 0;
  int        rcv_gap = 0;

  function automatic int rows_eff();
    return (scr_rows > MAX_ROWS) ? MAX_ROWS : scr_rows;
  endfunction

  function automatic bit on_scr(int x, int y);
    return x >= 0 && x < COLS && y >= 0 && y < rows_eff();
  endfunction

  // cursor is kept modulo 128
  function automatic void move_cursor(int x, int y);
    cur_x = x[6:0];
    cur_y = y[6:0];
  endfunction

  function automatic void put_cell(int x, int y, byte unsigned c);
    if (!on_scr(x, y)) return;
    char_mem[y * COLS + x] = c;
    color_mem[y * COLS + x] = {col_back[5:0], col_fore[5:0]};
  endfunction

  // scroll copy: off-screen source reads as blank with colour zero
  function automatic void dup_cell(int x, int dy, int sy);
    byte unsigned c;
    logic [11:0]  k;
    c = 0;
    k = '0;
    if (!on_scr(x, dy)) return;
    if (on_scr(x, sy)) begin
      c = char_mem[sy * COLS + x];
      k = color_mem[sy * COLS + x];
    end
    char_mem[dy * COLS + x] = c;
    color_mem[dy * COLS + x] = k;
  endfunction

  function automatic void blank_row(int y);
    for (int x = a_left; x < a_left + a_width; x++) put_cell(x, y, 8'd0);
  endfunction

  function automatic void dup_row(int dy, int sy);
    for (int x = a_left; x < a_left + a_width; x++) dup_cell(x, dy, sy);
  endfunction

  function automatic void blank_area();
    for (int y = a_top; y < a_top + a_height; y++) blank_row(y);
  endfunction

  // positive d moves text up, negative down
  function automatic void scroll_lines(int d);
    int bh, ph, by;
    if (d == 0) return;
    bh = (d < 0) ? -d : d;
    if (bh >= a_height) begin
      blank_area();
      move_cursor(a_left, (d < 0) ? a_top : a_top + a_height - 1);
      return;
    end
    ph = a_height - bh;
    if (d > 0) begin
      for (int i = 0; i < ph; i++) dup_row(a_top + i, a_top + bh + i);
      by = a_top + ph;
      move_cursor(a_left, a_top + a_height - bh);
    end else begin
      for (int i = 0; i < ph; i++)
        dup_row(a_top + a_height - 1 - i, a_top + a_height - 1 - bh - i);
      by = a_top;
      move_cursor(a_left, a_top);
    end
    for (int i = 0; i < bh; i++) blank_row(by + i);
  endfunction

  // step right; at the end of the area either scroll or wrap to the top
  function automatic void step_cursor(bit may_scroll);
    int x, y;
    x = int'(cur_x) + 1;
    y = int'(cur_y);
    if (x >= a_left + a_width) begin
      x = a_left;
      y++;
      if (y >= a_top + a_height) begin
        if (may_scroll) begin
          move_cursor(x, a_top + a_height - 1);
          scroll_lines(1);
          return;
        end
        y = a_top;
      end
    end
    move_cursor(x, y);
  endfunction

  function automatic void feed_line();
    int y;
    y = int'(cur_y);
    for (int x = int'(cur_x); x < a_left + a_width; x++) put_cell(x, y, 8'd0);
    y++;
    if (y >= a_top + a_height) begin
      move_cursor(a_left, a_top + a_height - 1);
      scroll_lines(1);
    end else begin
      move_cursor(a_left, y);
    end
  endfunction

  function automatic res_item_t model_command(cmd_item_t it);
    res_item_t r;
    int px, py;
    r = '0;
    px = int'(it.pos_x);
    py = int'(it.pos_y);
    case (it.cmd)
      CMD_PRINT: begin
        if (it.data_byte == CH_CR) move_cursor(a_left, int'(cur_y));
        else if (it.data_byte == CH_LF) feed_line();
        else if (it.data_byte == CH_FF) begin
          blank_area();
          move_cursor(a_left, a_top + a_height - 1);
        end else begin
          put_cell(int'(cur_x), int'(cur_y), it.data_byte);
          step_cursor(1'b1);
        end
      end
      CMD_PUT: begin
        put_cell(int'(cur_x), int'(cur_y), it.data_byte);
        step_cursor(1'b0);
      end
      CMD_GOTO: begin
        if (px < a_width && py < a_height) move_cursor(a_left + px, a_top + py);
      end
      CMD_SCROLL: scroll_lines(int'(it.scroll_amount));
      CMD_CLEAR: blank_area();
      CMD_READ: begin
        if (on_scr(px, py)) begin
          r.cell_char = char_mem[py * COLS + px];
          r.cell_back = color_mem[py * COLS + px][11:6];
          r.cell_fore = color_mem[py * COLS + px][5:0];
        end
      end
      default: ;
    endcase
    r.cursor_col = cur_x;
    r.cursor_row = cur_y;
    return r;
  endfunction

  // command sender: predicts at acceptance, idles in bursts
  always @(posedge clk) begin : drive
    bit v;
    if (rst) begin
      cmd_valid <= 1'b0;
      snd_gap = 0;
    end else begin
      v = cmd_valid;
      if (cmd_valid && cmd_ready) begin
        pending_results.push_back(model_command(cmd_item));
        v = 1'b0;
      end
      if (!v) begin
        if (snd_gap > 0) snd_gap--;
        else if (queued_cmds.size() > 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) snd_gap = $urandom_range(1, 6);
          else begin
            cmd_item <= queued_cmds.pop_front();
            v = 1'b1;
          end
        end
      end
      cmd_valid <= v;
    end
  end

  // result checker with random back-pressure
  always @(posedge clk) begin : watch
    res_item_t e;
    if (rst) begin
      res_ready <= 1'b0;
      rcv_gap = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", res_item);
        end else begin
          e = pending_results.pop_front();
          if (res_item.cursor_col !== e.cursor_col || res_item.cursor_row !== e.cursor_row ||
              res_item.cell_char !== e.cell_char || res_item.cell_back !== e.cell_back ||
              res_item.cell_fore !== e.cell_fore) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected col %0d row %0d char %h back %h fore %h,",
                        " got col %0d row %0d char %h back %h fore %h"},
                       e.cursor_col, e.cursor_row, e.cell_char, e.cell_back, e.cell_fore,
                       res_item.cursor_col, res_item.cursor_row, res_item.cell_char,
                       res_item.cell_back, res_item.cell_fore);
          end
        end
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        res_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rcv_gap = $urandom_range(0, 5);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // register write over the config port; mirror updated at the write edge
  task automatic set_reg(logic [2:0] idx, int val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_AREA_LEFT:   a_left = val & 8'h7F;
      REG_AREA_TOP:    a_top = val & 8'h7F;
      REG_AREA_WIDTH:  a_width = val & 8'h7F;
      REG_AREA_ROWS:   a_height = val & 8'hFF;
      REG_SCREEN_ROWS: scr_rows = val & 8'hFF;
      REG_COLOR_BACK:  col_back = val & 8'h3F;
      REG_COLOR_FORE:  col_fore = val & 8'h3F;
      default: ;
    endcase
  endtask

  task automatic set_area(int l, int t, int w, int h, int rows, int b, int f);
    set_reg(REG_AREA_LEFT, l);
    set_reg(REG_AREA_TOP, t);
    set_reg(REG_AREA_WIDTH, w);
    set_reg(REG_AREA_ROWS, h);
    set_reg(REG_SCREEN_ROWS, rows);
    set_reg(REG_COLOR_BACK, b);
    set_reg(REG_COLOR_FORE, f);
  endtask

  function automatic cmd_item_t mk(logic [2:0] c, int d, int x, int y, int s);
    cmd_item_t it;
    it.cmd = c;
    it.data_byte = d[7:0];
    it.pos_x = x[6:0];
    it.pos_y = y[6:0];
    it.scroll_amount = s[15:0];
    return it;
  endfunction

  // random command; scroll, clear, line feed and form feed only when heavy is allowed
  function automatic cmd_item_t rand_cmd(bit heavy);
    cmd_item_t   it;
    int          w;
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    it = r64[$bits(cmd_item_t)-1:0];
    w = $urandom_range(0, 99);
    if (w < 45) begin
      it.cmd = CMD_PRINT;
      case ($urandom_range(0, 19))
        0, 1:  it.data_byte = CH_CR;
        2, 3:  it.data_byte = heavy ? CH_LF : 8'h41;
        4:     it.data_byte = heavy ? CH_FF : 8'h42;
        default: begin
          if (!heavy && (it.data_byte == CH_LF || it.data_byte == CH_FF))
            it.data_byte = 8'h2E;
        end
      endcase
    end else if (w < 60) it.cmd = CMD_PUT;
    else if (w < 72) begin
      it.cmd = CMD_GOTO;
      if ($urandom_range(0, 3) != 0) begin
        it.pos_x = 7'($urandom_range(0, a_width));
        it.pos_y = 7'($urandom_range(0, a_height));
      end
    end else if (w < 79) begin
      it.cmd = heavy ? CMD_SCROLL : CMD_GOTO;
      case ($urandom_range(0, 7))
        0: it.scroll_amount = 16'sh7FFF;
        1: it.scroll_amount = 16'sh8000;
        2, 3: ;
        default: it.scroll_amount =
                   16'($urandom_range(0, 2 * a_height + 2) - a_height - 1);
      endcase
    end else if (w < 82) it.cmd = heavy ? CMD_CLEAR : CMD_READ;
    else if (w < 98) begin
      it.cmd = CMD_READ;
      if ($urandom_range(0, 2) != 0) begin
        it.pos_x = 7'(a_left + $urandom_range(0, a_width));
        it.pos_y = 7'(a_top + $urandom_range(0, a_height));
      end
    end else it.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
    return it;
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (queued_cmds.size() != 0 || cmd_valid || pending_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stim
    int l, t, w, h, n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, every command and the corner cases
    queued_cmds.push_back(mk(CMD_PRINT, 8'h41, 0, 0, 0));
    queued_cmds.push_back(mk(CMD_PRINT, 8'h00, 0, 0, 0));
    queued_cmds.push_back(mk(CMD_PRINT, 8'hFF, 127, 127, -1));
    queued_cmds.push_back(mk(CMD_PRINT, CH_CR, 0, 0, 0));
    queued_cmds.push_back(mk(CMD_PRINT, CH_LF, 0, 0, 0));
    queued_cmds.push_back(mk(CMD_GOTO, 0, 79, 29, 0));
    queued_cmds.push_back(mk(CMD_PUT, 8'h0D, 0, 0, 0));       // put wraps to the top
    queued_cmds.push_back(mk(CMD_GOTO, 0, 79, 29, 0));
    queued_cmds.push_back(mk(CMD_PRINT, 8'h7E, 0, 0, 0));     // print at the end scrolls
    queued_cmds.push_back(mk(CMD_GOTO, 0, 80, 0, 0));         // outside area, ignored
    queued_cmds.push_back(mk(CMD_GOTO, 0, 127, 127, 0));
    queued_cmds.push_back(mk(CMD_GOTO, 0, 5, 3, 0));
    queued_cmds.push_back(mk(CMD_PUT, 8'hFF, 0, 0, 0));
    queued_cmds.push_back(mk(CMD_SCROLL, 0, 0, 0, 0));
    queued_cmds.push_back(mk(CMD_SCROLL, 0, 0, 0, 1));
    queued_cmds.push_back(mk(CMD_SCROLL, 0, 0, 0, -1));
    queued_cmds.push_back(mk(CMD_SCROLL, 0, 0, 0, 32767));
    queued_cmds.push_back(mk(CMD_SCROLL, 0, 0, 0, -32768));
    queued_cmds.push_back(mk(CMD_PRINT, CH_FF, 0, 0, 0));
    queued_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0));
    queued_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
    queued_cmds.push_back(mk(CMD_READ, 0, 79, 29, 0));
    queued_cmds.push_back(mk(CMD_READ, 0, 127, 127, 0));
    queued_cmds.push_back(mk(CMD_SPARE_6, 8'hFF, 127, 127, -1));
    queued_cmds.push_back(mk(CMD_SPARE_7, 0, 0, 0, 0));
    wait_idle();   // stimulus waits until every result is back

    // extreme corners: area past the screen edge, cursor wraps modulo 128
    set_area(79, 127, 80, 128, 128, 63, 0);
    for (int i = 0; i < 30; i++) queued_cmds.push_back(rand_cmd(1'b0));
    queued_cmds.push_back(mk(CMD_PRINT, CH_FF, 0, 0, 0));
    wait_idle();
    set_area(0, 0, 1, 1, 1, 0, 63);
    for (int i = 0; i < 40; i++) queued_cmds.push_back(rand_cmd(1'b1));
    wait_idle();
    set_area(0, 0, 80, 128, 128, 21, 42);
    for (int i = 0; i < 25; i++) queued_cmds.push_back(rand_cmd(1'b0));
    queued_cmds.push_back(mk(CMD_SCROLL, 0, 0, 0, 127));
    wait_idle();

    // random phases with small areas
    for (int p = 0; p < 14; p++) begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 10);
      l = ($urandom_range(0, 3) == 0) ? 80 - w : $urandom_range(0, 79);
      t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 127);
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 128)
                                      : ((t + h > 128) ? 128 : t + h);
      set_area(l, t, w, h, n, $urandom_range(0, 63), $urandom_range(0, 63));
      if (p >= 12) quiet = 1'b1;
      for (int i = 0; i < 55; i++) queued_cmds.push_back(rand_cmd(1'b1));
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #100000000;
    $display("FAILURE");
    $finish;
  end

endmodule
